FILE: sv/wcmm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wcmm_pkg
// Shared constants, register indexes and types for the waveform column
// min/max overview core.
// ----------------------------------------------------------------------------
package wcmm_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int SAMPLE_BITS = 24;

    localparam int IDX_W     = 28;   // sample index
    localparam int COL_W     = 13;   // column counter / column count register
    localparam int FRAC_W    = 16;   // Q16.16 fraction bits
    localparam int ACC_W     = IDX_W + FRAC_W;
    localparam int SPC_W     = 32;
    localparam int SPC_INT_W = SPC_W - FRAC_W;
    localparam int HEIGHT_W  = 13;
    localparam int ROW_W     = 16;
    localparam int COL_OUT_W = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPC    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP   = 2'd3;

    // reset values
    localparam logic [SPC_W-1:0]    SPC_ONE      = 32'h0001_0000;
    localparam logic [COL_W-1:0]    COLS_RESET   = 13'd1;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd100;

    // 0.5 in Q8.16
    localparam logic signed [SAMPLE_BITS-1:0] HALF_Q16 = 24'sd32768;

    typedef struct packed {
        logic [SPC_W-1:0]    samples_per_column;
        logic [COL_W-1:0]    column_count;
        logic [HEIGHT_W-1:0] view_height;
        logic                clip_enable;
    } cfg_t;

    // closed column, extremes already clipped when clipping is enabled
    typedef struct packed {
        logic [COL_OUT_W-1:0]          column;
        logic signed [SAMPLE_BITS-1:0] top_val;
        logic signed [SAMPLE_BITS-1:0] bot_val;
        logic                          last;
    } col_event_t;

endpackage
`default_nettype wire

FILE: sv/wcmm_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wcmm_tracker
// Column position tracking and running min/max; registers one closed-column
// event for the row scaling stage.
// ----------------------------------------------------------------------------
module wcmm_tracker
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   accept,
    input  wire logic signed [wcmm_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic                                   restart,
    input  wire wcmm_pkg::cfg_t                         cfg,
    input  wire logic                                   ev_take,
    output logic                                        ev_valid,
    output wcmm_pkg::col_event_t                        ev
);

    localparam int IW = wcmm_pkg::IDX_W;
    localparam int CW = wcmm_pkg::COL_W;
    localparam int AW = wcmm_pkg::ACC_W;
    localparam int SB = wcmm_pkg::SAMPLE_BITS;

    logic [IW-1:0]        idx_reg, idx_next, eff_idx, start;
    logic [CW-1:0]        col_reg, col_next, eff_col, cols;
    logic [AW-1:0]        acc_reg, acc_next, eff_acc;
    logic signed [SB-1:0] max_reg, max_next, eff_max;
    logic signed [SB-1:0] min_reg, min_next, eff_min;
    logic                 fin_reg, fin_next, eff_fin;
    logic                 ev_valid_reg, ev_valid_next;
    wcmm_pkg::col_event_t ev_reg, ev_next;

    logic [wcmm_pkg::SPC_W-1:0]     spc_eff;
    logic [wcmm_pkg::SPC_INT_W-1:0] spc_int;
    logic [IW:0]                    last_idx;
    logic                           active, close, final_col;
    logic signed [SB-1:0]           max_upd, min_upd;

    always_comb
    begin
        // restart: behave as if state had just been reset
        eff_idx = restart ? '0 : idx_reg;
        eff_col = restart ? '0 : col_reg;
        eff_acc = restart ? '0 : acc_reg;
        eff_max = restart ? '0 : max_reg;
        eff_min = restart ? '0 : min_reg;
        eff_fin = restart ? 1'b0 : fin_reg;

        spc_eff = (cfg.samples_per_column < wcmm_pkg::SPC_ONE) ?
                  wcmm_pkg::SPC_ONE : cfg.samples_per_column;
        spc_int = spc_eff[wcmm_pkg::SPC_W-1:wcmm_pkg::FRAC_W];
        cols    = (cfg.column_count > CW'(wcmm_pkg::MAX_COLUMNS)) ?
                  CW'(wcmm_pkg::MAX_COLUMNS) : cfg.column_count;

        start    = eff_acc[AW-1:wcmm_pkg::FRAC_W];
        last_idx = {1'b0, start} + (IW+1)'(spc_int) - (IW+1)'(1);

        active    = !eff_fin && (eff_col < cols) && (eff_idx >= start);
        close     = active && ({1'b0, eff_idx} >= last_idx);
        final_col = ({1'b0, eff_col} + (CW+1)'(1)) >= {1'b0, cols};

        max_upd = (active && (sample > eff_max)) ? sample : eff_max;
        min_upd = (active && (sample < eff_min)) ? sample : eff_min;

        // index saturates at all ones
        idx_next = (eff_idx != '1) ? eff_idx + IW'(1) : eff_idx;
        col_next = eff_col;
        acc_next = eff_acc;
        max_next = max_upd;
        min_next = min_upd;
        fin_next = eff_fin;
        if (close)
        begin
            max_next = '0;
            min_next = '0;
            acc_next = eff_acc + AW'(spc_eff);
            col_next = eff_col + CW'(1);
            fin_next = eff_fin | final_col;
        end

        ev_next.column  = eff_col[wcmm_pkg::COL_OUT_W-1:0];
        ev_next.top_val = (cfg.clip_enable && (max_upd > wcmm_pkg::HALF_Q16)) ?
                          wcmm_pkg::HALF_Q16 : max_upd;
        ev_next.bot_val = (cfg.clip_enable && (min_upd < -wcmm_pkg::HALF_Q16)) ?
                          -wcmm_pkg::HALF_Q16 : min_upd;
        ev_next.last    = final_col;

        if (accept && close)
            ev_valid_next = 1'b1;
        else if (ev_take)
            ev_valid_next = 1'b0;
        else
            ev_valid_next = ev_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            col_reg      <= '0;
            acc_reg      <= '0;
            max_reg      <= '0;
            min_reg      <= '0;
            fin_reg      <= 1'b0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            ev_valid_reg <= ev_valid_next;
            if (accept)
            begin
                idx_reg <= idx_next;
                col_reg <= col_next;
                acc_reg <= acc_next;
                max_reg <= max_next;
                min_reg <= min_next;
                fin_reg <= fin_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && close)
            ev_reg <= ev_next;
    end

    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;

`ifndef NO_ASSERTIONS
    // closing the final column ends the pass
    a_final_ends_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && close && final_col) |=> fin_reg)
        else $error("pass not finished after final column");

    // column counter never runs past the column limit
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= CW'(wcmm_pkg::MAX_COLUMNS))
        else $error("column counter beyond limit");

    // extremes start at zero, so max never drops below it and min never rises above
    a_extreme_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (max_reg >= 0) && (min_reg <= 0))
        else $error("running extremes crossed zero");
`endif

endmodule
`default_nettype wire

FILE: sv/wcmm_row_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wcmm_row_map
// Maps a Q8.16 level to a pixel row: middle + floor(0.5 - v*height),
// saturated to 16 bits.
// ----------------------------------------------------------------------------
module wcmm_row_map
(
    input  wire logic signed [wcmm_pkg::SAMPLE_BITS-1:0] level,
    input  wire logic [wcmm_pkg::HEIGHT_W-1:0]           height,
    output logic signed [wcmm_pkg::ROW_W-1:0]           row
);

    localparam int SB     = wcmm_pkg::SAMPLE_BITS;
    localparam int HW     = wcmm_pkg::HEIGHT_W;
    localparam int PROD_W = SB + HW + 1;
    localparam int DIFF_W = PROD_W + 1;
    localparam int OFF_W  = DIFF_W - wcmm_pkg::FRAC_W;
    localparam int SUM_W  = OFF_W + 1;
    localparam logic signed [SUM_W-1:0] ROW_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] ROW_MIN = -SUM_W'(32768);

    logic signed [PROD_W-1:0] prod;
    logic signed [DIFF_W-1:0] diff;
    logic signed [OFF_W-1:0]  offset;
    logic signed [SUM_W-1:0]  mid, sum;

    always_comb
    begin
        prod   = level * $signed({1'b0, height});
        diff   = DIFF_W'(wcmm_pkg::HALF_Q16) - DIFF_W'(prod);
        // arithmetic shift = floor toward minus infinity
        offset = diff[DIFF_W-1:wcmm_pkg::FRAC_W];
        mid    = $signed(SUM_W'(height[HW-1:1]));
        sum    = SUM_W'(offset) + mid;
        if (sum > ROW_MAX)
            row = ROW_MAX[wcmm_pkg::ROW_W-1:0];
        else if (sum < ROW_MIN)
            row = ROW_MIN[wcmm_pkg::ROW_W-1:0];
        else
            row = sum[wcmm_pkg::ROW_W-1:0];
    end

endmodule
`default_nettype wire

FILE: sv/waveform_column_min_max_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// waveform_column_min_max_core
// Min/max decimation of an audio sample stream into display columns.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         content
//  s_*       in   tvalid/tready     sample (tdata), restart marker (tuser)
//  m_*       out  tvalid/tready     column, top/bottom rows (tdata), last col (tlast)
//  cfg_*     in   cfg_we            register index + write data, no read-back
//
//  Throughput: one sample request per cycle, except under m_tready back-pressure.
//  Path: a closing sample's column passes the event register, then row
//  scaling multiply into the output register, before it leaves.
//  Reset: registers to defaults (1.0 spc, 1 column, height 100, no clip),
//  tracking state and both pipeline valid flags cleared.
//  Stalls: m_tready low holds the output register; the event register
//  still fills, and only then does s_tready drop.
// ----------------------------------------------------------------------------
module waveform_column_min_max_core
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [23:0]                       s_tdata,   // [23:0] sample
    input  wire logic                              s_tuser,   // [0] restart

    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [47:0]                            m_tdata,   // [11:0] column,
                                                              // [27:12] top_row,
                                                              // [43:28] bottom_row,
                                                              // [47:44] zero
    output logic                                   m_tlast,   // last_column

    input  wire logic                              cfg_we,
    input  wire logic [wcmm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [wcmm_pkg::CFG_DAT_W-1:0]    cfg_data
);

    localparam int ROW_W = wcmm_pkg::ROW_W;

    wcmm_pkg::cfg_t       cfg_reg;
    wcmm_pkg::col_event_t ev;
    logic                 ev_valid, ev_take, out_adv, accept;
    logic                 o_valid_reg, o_valid_next;
    logic [47:0]          o_data_reg;
    logic                 o_last_reg;
    logic signed [ROW_W-1:0] top_row, bottom_row;

    // ---- configuration registers -----------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.samples_per_column <= wcmm_pkg::SPC_ONE;
            cfg_reg.column_count       <= wcmm_pkg::COLS_RESET;
            cfg_reg.view_height        <= wcmm_pkg::HEIGHT_RESET;
            cfg_reg.clip_enable        <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wcmm_pkg::REG_SPC:    cfg_reg.samples_per_column <= cfg_data;
                wcmm_pkg::REG_COLS:   cfg_reg.column_count <=
                                          cfg_data[wcmm_pkg::COL_W-1:0];
                wcmm_pkg::REG_HEIGHT: cfg_reg.view_height <=
                                          cfg_data[wcmm_pkg::HEIGHT_W-1:0];
                wcmm_pkg::REG_CLIP:   cfg_reg.clip_enable <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---- flow control ------------------------------------------------------
    // output register frees when empty or taken; event register drains into it
    assign out_adv  = !o_valid_reg || m_tready;
    assign ev_take  = ev_valid && out_adv;
    assign s_tready = !ev_valid || out_adv;
    assign accept   = s_tvalid && s_tready;

    // ---- column tracking ---------------------------------------------------
    wcmm_tracker u_tracker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .sample   ($signed(s_tdata[wcmm_pkg::SAMPLE_BITS-1:0])),
        .restart  (s_tuser),
        .cfg      (cfg_reg),
        .ev_take  (ev_take),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    // ---- row scaling for max and min --------------------------------------
    wcmm_row_map u_top_map
    (
        .level  (ev.top_val),
        .height (cfg_reg.view_height),
        .row    (top_row)
    );

    wcmm_row_map u_bot_map
    (
        .level  (ev.bot_val),
        .height (cfg_reg.view_height),
        .row    (bottom_row)
    );

    // ---- output register ---------------------------------------------------
    always_comb
    begin
        if (ev_take)
            o_valid_next = 1'b1;
        else if (m_tready)
            o_valid_next = 1'b0;
        else
            o_valid_next = o_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else
            o_valid_reg <= o_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ev_take)
        begin
            o_data_reg <= {4'b0000, bottom_row, top_row, ev.column};
            o_last_reg <= ev.last;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tlast  = o_last_reg;

`ifndef NO_ASSERTIONS
    // both pipeline registers full and output stalled: no new sample request
    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_valid && o_valid_reg && !m_tready) |-> !s_tready)
        else $error("sample accepted with pipeline full");

    // output taken with nothing behind it empties the output register
    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !ev_valid) |=> !m_tvalid)
        else $error("result repeated after drain");
`endif

endmodule
`default_nettype wire
